>>> rtl/djb2_linear_probe_hash_table_assert.svh
// Assertion macros for the djb2 linear-probe hash table.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef DJB2_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define DJB2_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DLPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DLPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/djb2lp_pkg.sv
// Shared types and constants for the djb2 linear-probe hash table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package djb2lp_pkg;

  // fixed field widths
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int CAP_W    = 9;
  localparam int SLOT_W   = 8;
  localparam int CNT_W    = 9;
  localparam int STATUS_W = 3;

  // djb2 hash
  localparam int                HASH_W     = 32;
  localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  // byte counter holds 0..8
  localparam int BYTE_CNT_W = 4;

  // modulo unit: two remainder bits per cycle
  localparam int MOD_STEPS = HASH_W / 2;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_UPDATED   = 3'd1;
  localparam status_t ST_FOUND     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

  localparam logic KIND_PUT    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

endpackage

`default_nettype wire

>>> rtl/djb2_linear_probe_hash_table.sv
// Work per word: the byte-serial hash step, the 2-bit-per-cycle modulo unit and a
// read-then-compare per probed slot, ending in the done strobe. A new word is taken
// only while idle and may start in the done cycle.
// Reset (rst, synchronous) runs a clearing pass over the slot-used memory with busy
// high; config writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

`include "djb2_linear_probe_hash_table_assert.svh"

module djb2_linear_probe_hash_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BITS  = 64
) (
  input  wire                                    clk,
  input  wire                                    rst,
  // command channel
  input  wire                                    start,
  output logic                                   busy,
  input  wire                                    kind,
  input  wire  [djb2lp_pkg::KEY_W-1:0]           key,
  input  wire  [djb2lp_pkg::VAL_W-1:0]           value,
  // capacity register write channel
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [djb2lp_pkg::CAP_W-1:0]           cfg_data,
  // result
  output logic                                   done,
  output djb2lp_pkg::status_t                    status,
  output logic [djb2lp_pkg::VAL_W-1:0]           value_out,
  output logic [djb2lp_pkg::SLOT_W-1:0]          slot,
  output logic [djb2lp_pkg::CNT_W-1:0]           entry_count
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int KW   = 8 * KEY_BYTES;
  localparam int OCW  = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (AW + 1 > djb2lp_pkg::CAP_W) ? AW + 1 : djb2lp_pkg::CAP_W;
  localparam int CW   = djb2lp_pkg::CAP_W;
  localparam int HW   = djb2lp_pkg::HASH_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_PADDR = 3'd4;
  localparam logic [2:0] S_PCHK  = 3'd5;

  logic [2:0]                            state;
  logic [CW-1:0]                         capacity_in_use;
  logic [AW-1:0]                         clr;
  logic                                  kind_r;
  logic [djb2lp_pkg::KEY_W-1:0]          key_raw;
  logic [djb2lp_pkg::KEY_W-1:0]          canon;
  logic [VALUE_BITS-1:0]                 val_r;
  logic [djb2lp_pkg::BYTE_CNT_W-1:0]     bi;
  logic [HW-1:0]                         h;
  logic [djb2lp_pkg::MOD_CNT_W-1:0]      mc;
  logic [CW-1:0]                         rem;
  logic [AW-1:0]                         pos;
  logic [CW-1:0]                         n;
  logic [OCW-1:0]                        occ;

  // memories and their registered read data
  logic                                  used_mem [TABLE_DEPTH];
  logic [KW-1:0]                         key_mem  [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]                 val_mem  [TABLE_DEPTH];
  logic                                  used_q;
  logic [KW-1:0]                         key_q;
  logic [VALUE_BITS-1:0]                 val_q;

  logic                                  used_we;
  logic                                  used_wd;
  logic [AW-1:0]                         used_wa;
  logic                                  key_we;
  logic                                  val_we;

  logic [CW-1:0]                         cap;
  logic [7:0]                            cur_byte;
  logic                                  hash_end;
  logic [HW-1:0]                         h_step;
  logic [CW:0]                           mt0;
  logic [CW:0]                           mt1;
  logic [CW-1:0]                         mr0;
  logic [CW-1:0]                         rem_next;
  logic                                  chk_empty;
  logic                                  chk_hit;
  logic                                  chk_last;
  logic [CMPW-1:0]                       pos_inc;
  logic [AW-1:0]                         pos_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // effective capacity: zero acts as one, clipped to the table depth
  always_comb begin
    if (capacity_in_use == '0) begin
      cap = CW'(1);
    end else if (CMPW'(capacity_in_use) > CMPW'(TABLE_DEPTH)) begin
      cap = CW'(TABLE_DEPTH);
    end else begin
      cap = capacity_in_use;
    end
  end

  // hash step: h*33 + byte
  assign cur_byte = key_raw[8*bi[2:0] +: 8];
  assign hash_end = (bi == djb2lp_pkg::BYTE_CNT_W'(KEY_BYTES)) || (cur_byte == 8'd0);
  assign h_step   = (h << djb2lp_pkg::HASH_SHIFT) + h + HW'(cur_byte);

  // modulo step: two restoring-division bits per cycle, hash MSB first
  always_comb begin
    mt0 = {rem, h[HW-1]};
    if (mt0 >= {1'b0, cap}) begin
      mr0 = CW'(mt0 - {1'b0, cap});
    end else begin
      mr0 = mt0[CW-1:0];
    end
    mt1 = {mr0, h[HW-2]};
    if (mt1 >= {1'b0, cap}) begin
      rem_next = CW'(mt1 - {1'b0, cap});
    end else begin
      rem_next = mt1[CW-1:0];
    end
  end

  // probe compare and wraparound
  assign chk_empty = !used_q;
  assign chk_hit   = used_q && (key_q == canon[KW-1:0]);
  assign chk_last  = ((n + CW'(1)) == cap);
  assign pos_inc   = CMPW'(pos) + CMPW'(1);
  assign pos_next  = (pos_inc >= CMPW'(cap)) ? '0 : AW'(pos_inc);

  // memory write controls
  always_comb begin
    used_we = 1'b0;
    used_wd = 1'b0;
    used_wa = pos;
    key_we  = 1'b0;
    val_we  = 1'b0;
    case (state)
      S_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr;
      end
      S_PCHK: begin
        if (kind_r == djb2lp_pkg::KIND_PUT) begin
          if (chk_empty) begin
            used_we = 1'b1;
            used_wd = 1'b1;
            key_we  = 1'b1;
            val_we  = 1'b1;
          end else if (chk_hit) begin
            val_we  = 1'b1;
          end
        end
      end
      default: begin
        used_we = 1'b0;
      end
    endcase
  end

  // slot-used memory
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_q <= used_mem[pos];
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[pos] <= canon[KW-1:0];
    end
    key_q <= key_mem[pos];
  end

  // value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[pos] <= val_r;
    end
    val_q <= val_mem[pos];
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= djb2lp_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_in_use <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_r  <= kind;
            key_raw <= key;
            val_r   <= value[VALUE_BITS-1:0];
            canon   <= '0;
            bi      <= '0;
            h       <= djb2lp_pkg::HASH_START;
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_end) begin
            mc    <= '0;
            rem   <= '0;
            state <= S_MOD;
          end else begin
            h                    <= h_step;
            canon[8*bi[2:0] +: 8] <= cur_byte;
            bi                   <= bi + djb2lp_pkg::BYTE_CNT_W'(1);
          end
        end
        S_MOD: begin
          rem <= rem_next;
          h   <= h << 2;
          mc  <= mc + djb2lp_pkg::MOD_CNT_W'(1);
          if (mc == djb2lp_pkg::MOD_CNT_W'(djb2lp_pkg::MOD_STEPS - 1)) begin
            pos   <= AW'(rem_next);
            n     <= '0;
            state <= S_PADDR;
          end
        end
        S_PADDR: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (chk_empty || chk_hit || chk_last) begin
            done      <= 1'b1;
            state     <= S_IDLE;
            value_out <= '0;
            slot      <= '0;
            entry_count <= djb2lp_pkg::CNT_W'(occ);
            if (kind_r == djb2lp_pkg::KIND_PUT) begin
              if (chk_hit) begin
                status    <= djb2lp_pkg::ST_UPDATED;
                value_out <= djb2lp_pkg::VAL_W'(val_r);
                slot      <= djb2lp_pkg::SLOT_W'(pos);
              end else if (chk_empty) begin
                status      <= djb2lp_pkg::ST_INSERTED;
                value_out   <= djb2lp_pkg::VAL_W'(val_r);
                slot        <= djb2lp_pkg::SLOT_W'(pos);
                occ         <= occ + OCW'(1);
                entry_count <= djb2lp_pkg::CNT_W'(occ + OCW'(1));
              end else begin
                status <= djb2lp_pkg::ST_FULL;
              end
            end else begin
              if (chk_hit) begin
                status    <= djb2lp_pkg::ST_FOUND;
                value_out <= djb2lp_pkg::VAL_W'(val_q);
                slot      <= djb2lp_pkg::SLOT_W'(pos);
              end else begin
                status <= djb2lp_pkg::ST_NOT_FOUND;
              end
            end
          end else begin
            pos   <= pos_next;
            n     <= n + CW'(1);
            state <= S_PADDR;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `DLPHT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `DLPHT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not start work")
  `DLPHT_ASSERT_NOW(a_miss_zero, done && (status == djb2lp_pkg::ST_NOT_FOUND || status == djb2lp_pkg::ST_FULL), value_out == '0 && slot == '0, "miss result carries data")
  `DLPHT_ASSERT_NOW(a_occ_bound, 1'b1, OCW'(occ) <= OCW'(TABLE_DEPTH), "occupied count above table depth")
  `DLPHT_ASSERT_NEXT(a_occ_insert, state == S_PCHK && !(kind_r == djb2lp_pkg::KIND_PUT && chk_empty), occ == $past(occ), "occupied count moved without an insert")

endmodule

`default_nettype wire

>>> test/djb2_linear_probe_hash_table_tb.sv
// Self-checking testbench for the djb2 linear-probe hash table: put/lookup words
// against an in-bench table predictor, with capacity rewrites between phases.
// Depends on djb2lp_pkg and the djb2_linear_probe_hash_table top level.
`timescale 1ns / 1ps

module djb2_linear_probe_hash_table_tb;

  localparam int DEPTH       = 256;
  localparam int QUIET_LIMIT = 6000;
  localparam int END_PAUSE   = 600;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 160;

  typedef struct packed {
    logic                         kind;
    logic [djb2lp_pkg::KEY_W-1:0] key;
    logic [djb2lp_pkg::VAL_W-1:0] value;
  } table_cmd_t;

  typedef struct packed {
    djb2lp_pkg::status_t           status;
    logic [djb2lp_pkg::VAL_W-1:0]  value;
    logic [djb2lp_pkg::SLOT_W-1:0] slot;
    logic [djb2lp_pkg::CNT_W-1:0]  count;
  } table_result_t;

  // DUT signals
  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          start       = 1'b0;
  logic                          busy;
  logic                          kind        = djb2lp_pkg::KIND_PUT;
  logic [djb2lp_pkg::KEY_W-1:0]  key         = '0;
  logic [djb2lp_pkg::VAL_W-1:0]  value       = '0;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [djb2lp_pkg::CAP_W-1:0]  cfg_data    = '0;
  logic                          done;
  djb2lp_pkg::status_t           status;
  logic [djb2lp_pkg::VAL_W-1:0]  value_out;
  logic [djb2lp_pkg::SLOT_W-1:0] slot;
  logic [djb2lp_pkg::CNT_W-1:0]  entry_count;

  // table mirror
  logic [djb2lp_pkg::KEY_W-1:0] mirror_key [DEPTH];
  logic [djb2lp_pkg::VAL_W-1:0] mirror_val [DEPTH];
  bit                           mirror_used [DEPTH];
  int unsigned                  mirror_count = 0;
  logic [djb2lp_pkg::CAP_W-1:0] mirror_cap   = djb2lp_pkg::CAP_RESET;

  table_cmd_t    pending_words[$];
  table_result_t awaited_results[$];

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int cap_writes   = 0;
  int status_seen [5];
  int quiet_cycles = 0;

  // sender burst/gap state
  int         burst_left = 1;
  int         gap_left   = 0;
  table_cmd_t next_cmd;

  djb2_linear_probe_hash_table DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .key        (key),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .value_out  (value_out),
    .slot       (slot),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict one word: trim key at first zero byte, djb2 hash, linear probe.
  function automatic void probe_table(input logic op,
                                      input logic [djb2lp_pkg::KEY_W-1:0] raw_key,
                                      input logic [djb2lp_pkg::VAL_W-1:0] new_val);
    logic [djb2lp_pkg::KEY_W-1:0]  k;
    int unsigned                   len;
    logic [djb2lp_pkg::HASH_W-1:0] h;
    int unsigned                   cap;
    int unsigned                   pos;
    int unsigned                   n;
    bit                            hit;
    bit                            empty;
    table_result_t                 r;
    k   = '0;
    len = 0;
    while (len < 8 && raw_key[8*len +: 8] != 8'h00) begin
      k[8*len +: 8] = raw_key[8*len +: 8];
      len++;
    end
    h = djb2lp_pkg::HASH_START;
    for (int i = 0; i < len; i++) begin
      h = (h << djb2lp_pkg::HASH_SHIFT) + h + {24'b0, k[8*i +: 8]};
    end
    cap = mirror_cap;
    if (cap == 0) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    pos   = h % cap;
    hit   = 1'b0;
    empty = 1'b0;
    for (n = 0; n < cap && !hit && !empty; n++) begin
      if (!mirror_used[pos]) begin
        empty = 1'b1;
      end else if (mirror_key[pos] == k) begin
        hit = 1'b1;
      end else begin
        pos = (pos + 1 >= cap) ? 0 : pos + 1;
      end
    end
    r.value = '0;
    r.slot  = '0;
    if (op == djb2lp_pkg::KIND_PUT) begin
      if (hit) begin
        mirror_val[pos] = new_val;
        r.status = djb2lp_pkg::ST_UPDATED;
        r.value  = new_val;
        r.slot   = pos[djb2lp_pkg::SLOT_W-1:0];
      end else if (empty) begin
        mirror_used[pos] = 1'b1;
        mirror_key[pos]  = k;
        mirror_val[pos]  = new_val;
        mirror_count++;
        r.status = djb2lp_pkg::ST_INSERTED;
        r.value  = new_val;
        r.slot   = pos[djb2lp_pkg::SLOT_W-1:0];
      end else begin
        r.status = djb2lp_pkg::ST_FULL;
      end
    end else begin
      if (hit) begin
        r.status = djb2lp_pkg::ST_FOUND;
        r.value  = mirror_val[pos];
        r.slot   = pos[djb2lp_pkg::SLOT_W-1:0];
      end else begin
        r.status = djb2lp_pkg::ST_NOT_FOUND;
      end
    end
    r.count = mirror_count[djb2lp_pkg::CNT_W-1:0];
    awaited_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("MISMATCH t=%0t result %0d: %s got %h want %h", $time, results_seen, what,
               got, want);
    mismatches++;
  endtask

  // Driver: one word held until accepted, bursts separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        probe_table(kind, key, value);
        words_sent++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_cmd = pending_words.pop_front();
          start <= 1'b1;
          kind  <= next_cmd.kind;
          key   <= next_cmd.key;
          value <= next_cmd.value;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is checked against the oldest expectation
  always @(posedge clk) begin
    table_result_t want_r;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited, status", status, '0);
      end else begin
        want_r = awaited_results.pop_front();
        if (status !== want_r.status) report_mismatch("status", status, want_r.status);
        if (value_out !== want_r.value) report_mismatch("value_out", value_out, want_r.value);
        if (slot !== want_r.slot) report_mismatch("slot", slot, want_r.slot);
        if (entry_count !== want_r.count)
          report_mismatch("entry_count", entry_count, want_r.count);
        if (want_r.status <= djb2lp_pkg::ST_FULL) status_seen[want_r.status]++;
      end
      results_seen++;
    end
  end

  // Watchdog: stop if no handshake of any kind for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, awaited_results.size());
        $display("djb2_linear_probe_hash_table test failed");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input logic op, input logic [djb2lp_pkg::KEY_W-1:0] k,
                           input logic [djb2lp_pkg::VAL_W-1:0] v);
    table_cmd_t c;
    c.kind  = op;
    c.key   = k;
    c.value = v;
    pending_words.push_back(c);
  endtask

  // Block idle: all words sent and every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || awaited_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [djb2lp_pkg::CAP_W-1:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    mirror_cap  = cap;
    cap_writes++;
    @(negedge clk);
  endtask

  // Sometimes put random garbage above the terminating zero byte of a trimmed key under seven bytes
  function automatic logic [djb2lp_pkg::KEY_W-1:0] dress_key(
      input logic [djb2lp_pkg::KEY_W-1:0] canon, input int unsigned len);
    logic [djb2lp_pkg::KEY_W-1:0] junk;
    junk = {$urandom, $urandom};
    if (len >= 7 || $urandom_range(0, 1) == 0) return canon;
    return canon | (junk & ~((64'h1 << (8 * (len + 1))) - 1));
  endfunction

  initial begin
    logic [djb2lp_pkg::CAP_W-1:0] phase_caps [RAND_PHASES];
    logic [djb2lp_pkg::KEY_W-1:0] pool_key[$];
    int unsigned                  pool_len[$];
    logic [djb2lp_pkg::KEY_W-1:0] canon;
    int unsigned                  len;
    int unsigned                  pool_size;
    int unsigned                  r;
    int unsigned                  idx;
    logic [djb2lp_pkg::KEY_W-1:0] k;
    logic [djb2lp_pkg::VAL_W-1:0] v;
    logic                         op;

    phase_caps = '{9'd256, 9'd2, 9'd37, 9'd255, 9'd3, 9'd128, 9'd300, 9'd256};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // one-slot table: empty, insert, full, key with junk after terminator, update
    write_capacity(9'd1);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h41, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h41, {djb2lp_pkg::VAL_W{1'b1}});
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h42, 64'h1);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h42, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'hDEAD_0041, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h41, 64'h0);
    wait_idle();

    // zero capacity acts as one slot
    write_capacity(9'd0);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h41, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h0, 64'h7);
    wait_idle();

    // capacity above the table acts as full depth; entries stay where they are
    write_capacity(9'd511);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h0, 64'h8000_0000_0000_0000);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, {djb2lp_pkg::KEY_W{1'b1}}, {djb2lp_pkg::VAL_W{1'b1}});
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, {djb2lp_pkg::KEY_W{1'b1}}, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h0102_0304_0506_0708, 64'h5555_5555_5555_5555);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'hFEFD_FCFB_FAF9_F8F7, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h41, 64'h1234);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h43, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h1234_5600_7A7B, 64'h99);
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h7A7B, 64'h0);
    queue_cmd(djb2lp_pkg::KIND_PUT, 64'h7A7B, {djb2lp_pkg::VAL_W{1'b1}});
    queue_cmd(djb2lp_pkg::KIND_LOOKUP, 64'h0102_0304_0506_0708, 64'h0);
    wait_idle();

    // random phases: mostly puts/lookups of a key pool, some raw noise keys
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      if (p % 2 == 0) begin
        pool_key.delete();
        pool_len.delete();
      end
      pool_size = $urandom_range(4, 40);
      for (int i = 0; i < pool_size; i++) begin
        len   = $urandom_range(0, 8);
        canon = '0;
        for (int b = 0; b < len; b++) canon[8*b +: 8] = $urandom_range(1, 255);
        pool_key.push_back(canon);
        pool_len.push_back(len);
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          idx = $urandom_range(0, pool_key.size() - 1);
          k   = dress_key(pool_key[idx], pool_len[idx]);
          op  = (r < 45) ? djb2lp_pkg::KIND_PUT : djb2lp_pkg::KIND_LOOKUP;
        end else begin
          k  = {$urandom, $urandom};
          op = ($urandom_range(0, 1) == 0) ? djb2lp_pkg::KIND_PUT : djb2lp_pkg::KIND_LOOKUP;
        end
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = {djb2lp_pkg::VAL_W{1'b1}};
          default: v = {$urandom, $urandom};
        endcase
        queue_cmd(op, k, v);
      end
      wait_idle();
    end

    repeat (END_PAUSE) @(posedge clk);
    $display("covered %0d words over %0d capacity writes, %0d results checked",
             words_sent, cap_writes, results_seen);
    $display("inserted %0d updated %0d found %0d not found %0d full %0d, %0d slots used",
             status_seen[djb2lp_pkg::ST_INSERTED], status_seen[djb2lp_pkg::ST_UPDATED],
             status_seen[djb2lp_pkg::ST_FOUND], status_seen[djb2lp_pkg::ST_NOT_FOUND],
             status_seen[djb2lp_pkg::ST_FULL], mirror_count);
    if (mismatches == 0) begin
      $display("djb2_linear_probe_hash_table test passed");
    end else begin
      $display("djb2_linear_probe_hash_table test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/djb2lp_pkg.sv
rtl/djb2_linear_probe_hash_table.sv
test/djb2_linear_probe_hash_table_tb.sv
